// ===== sv/ipv4v_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv4v_pkg
// shared types and character constants for the address text validator
// ----------------------------------------------------------------------------
package ipv4v_pkg;

	localparam int unsigned CHAR_W  = 8;
	localparam int unsigned VALUE_W = 17;

	localparam logic [CHAR_W-1:0] CHAR_DOT   = 8'h2E;
	localparam logic [CHAR_W-1:0] CHAR_COLON = 8'h3A;
	localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;

	localparam logic [VALUE_W-1:0] PORT_MAX  = 17'd65535;
	localparam logic [VALUE_W-1:0] OCTET_MAX = 17'd255;
	localparam logic [VALUE_W-1:0] VALUE_SAT = 17'd65536;

	localparam logic [1:0] DOTS_FULL   = 2'd3;
	localparam logic [1:0] DIGITS_FULL = 2'd2;

	// verdict handed from the scanner to the output stage
	typedef struct packed {
		logic valid;
		logic address_valid;
	} verdict_t;

endpackage

// ===== sv/ipv4_port_text_validator_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv4_port_text_validator_unit
// checks an a.b.c.d:port text streamed one character per transfer
// ----------------------------------------------------------------------------
// usage:
//   s_* carries one character per transfer, tlast on the final character.
//   m_* carries one verdict per text, given for the tlast character only.
//   characters without tlast update the running state and give no output.
// timing:
//   one character per cycle while s_tready is high; the tlast verdict is
//   registered in the output entry (skid entry when held). per-character work
//   is a small field value update (times ten plus digit) and a few compares.
// stall:
//   the verdict sits in an output register with a one-entry skid behind it,
//   so s_tready stays high while one verdict waits; it drops only when both
//   the output and the skid entry hold verdicts.
// reset:
//   arst_n clears the text state and both output entries; the next
//   character begins a new text.
// ----------------------------------------------------------------------------
module ipv4_port_text_validator_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,  // [7:0] char_code
	input  logic       s_tlast,  // last_char
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata   // [0] address_valid, [7:1] zero
);
	import ipv4v_pkg::*;

	verdict_t verdict;
	logic     step;
	logic     out_vld_q;
	logic     out_bit_q;
	logic     skid_vld_q;
	logic     skid_bit_q;
	logic     out_free;

	assign s_tready = !skid_vld_q;
	assign step     = s_tvalid && s_tready;
	assign out_free = !out_vld_q || m_tready;

	ipv4v_scan u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.char_code (s_tdata),
		.last_char (s_tlast),
		.verdict   (verdict)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			out_bit_q  <= 1'b0;
			skid_vld_q <= 1'b0;
			skid_bit_q <= 1'b0;
		end else begin
			priority if (skid_vld_q) begin
				// no new verdict can arrive while skid is full
				if (out_free) begin
					out_vld_q  <= 1'b1;
					out_bit_q  <= skid_bit_q;
					skid_vld_q <= 1'b0;
				end
			end else if (verdict.valid) begin
				if (out_free) begin
					out_vld_q <= 1'b1;
					out_bit_q <= verdict.address_valid;
				end else begin
					skid_vld_q <= 1'b1;
					skid_bit_q <= verdict.address_valid;
				end
			end else begin
				if (m_tready) begin
					out_vld_q <= 1'b0;
				end
			end
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {7'd0, out_bit_q};

endmodule

// ===== sv/ipv4v_scan.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv4v_scan
// per-character state update and verdict on the marked last character
// ----------------------------------------------------------------------------
module ipv4v_scan (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       step,
	input  logic [ipv4v_pkg::CHAR_W-1:0] char_code,
	input  logic                       last_char,
	output ipv4v_pkg::verdict_t        verdict
);
	import ipv4v_pkg::*;

	logic [1:0]         dots_seen_q;
	logic               colon_seen_q;
	logic               failed_q;
	logic [VALUE_W-1:0] field_value_q;
	logic               prev_was_digit_q;
	logic [1:0]         digits_in_field_q;
	logic               field_starts_zero_q;

	logic [1:0]         dots_n;
	logic               colon_n;
	logic               failed_n;
	logic [VALUE_W-1:0] value_n;
	logic               prev_n;
	logic [1:0]         digits_n;
	logic               starts_zero_n;

	logic               is_digit;
	logic [3:0]         digit;
	logic [VALUE_W+3:0] value_x10;
	logic               octet_big;

	assign is_digit  = (char_code >= CHAR_ZERO) && (char_code <= CHAR_NINE);
	assign digit     = 4'(char_code - CHAR_ZERO);
	// times ten as two shifts and an add
	assign value_x10 = {field_value_q, 3'b000} + {2'b00, field_value_q, 1'b0}
		+ {17'd0, digit};
	assign octet_big = field_value_q > OCTET_MAX;

	always_comb begin
		dots_n        = dots_seen_q;
		colon_n       = colon_seen_q;
		failed_n      = failed_q;
		value_n       = '0;
		prev_n        = 1'b0;
		digits_n      = '0;
		starts_zero_n = 1'b0;
		priority if (is_digit) begin
			starts_zero_n = field_starts_zero_q;
			if (digits_in_field_q == 2'd0) begin
				starts_zero_n = (digit == 4'd0);
			end else if (field_starts_zero_q) begin
				failed_n = 1'b1;
			end
			digits_n = (digits_in_field_q < DIGITS_FULL) ? 2'(digits_in_field_q + 2'd1)
				: digits_in_field_q;
			value_n = (value_x10 > {4'd0, VALUE_SAT}) ? VALUE_SAT : value_x10[VALUE_W-1:0];
			if (value_n > PORT_MAX) begin
				failed_n = 1'b1;
			end
			prev_n = 1'b1;
		end else if (char_code == CHAR_DOT) begin
			if (!prev_was_digit_q || colon_seen_q || dots_seen_q == DOTS_FULL || octet_big) begin
				failed_n = 1'b1;
			end
			if (dots_seen_q != DOTS_FULL) begin
				dots_n = 2'(dots_seen_q + 2'd1);
			end
		end else if (char_code == CHAR_COLON) begin
			if (!prev_was_digit_q || colon_seen_q || dots_seen_q != DOTS_FULL || octet_big) begin
				failed_n = 1'b1;
			end
			colon_n = 1'b1;
		end else begin
			failed_n = 1'b1;
		end
	end

	always_comb begin
		verdict.valid         = step && last_char;
		verdict.address_valid = !failed_n && (dots_n == DOTS_FULL) && colon_n && prev_n
			&& (value_n <= PORT_MAX);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dots_seen_q         <= '0;
			colon_seen_q        <= 1'b0;
			failed_q            <= 1'b0;
			field_value_q       <= '0;
			prev_was_digit_q    <= 1'b0;
			digits_in_field_q   <= '0;
			field_starts_zero_q <= 1'b0;
		end else if (step) begin
			if (last_char) begin
				// text done, next transfer starts a new one
				dots_seen_q         <= '0;
				colon_seen_q        <= 1'b0;
				failed_q            <= 1'b0;
				field_value_q       <= '0;
				prev_was_digit_q    <= 1'b0;
				digits_in_field_q   <= '0;
				field_starts_zero_q <= 1'b0;
			end else begin
				dots_seen_q         <= dots_n;
				colon_seen_q        <= colon_n;
				failed_q            <= failed_n;
				field_value_q       <= value_n;
				prev_was_digit_q    <= prev_n;
				digits_in_field_q   <= digits_n;
				field_starts_zero_q <= starts_zero_n;
			end
		end
	end

endmodule

// ===== tb/ipv4_port_text_validator_unit_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv4_port_text_validator_unit_checker
// watches both streams, predicts each text verdict and compares it with the
// verdict transfer that comes out of the validator
// ----------------------------------------------------------------------------
module ipv4_port_text_validator_unit_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	input  logic       s_tready,
	input  logic [7:0] s_tdata,  // [7:0] char_code
	input  logic       s_tlast,  // last_char
	input  logic       m_tvalid,
	input  logic       m_tready,
	input  logic [7:0] m_tdata,  // [0] address_valid, [7:1] zero
	output int         errors,
	output int         pending
);
	import ipv4v_pkg::*;

	// running scan state of the text being received
	logic [1:0]         dots;
	logic               colon_hit;
	logic               broken;
	logic [VALUE_W-1:0] number;
	logic               prev_digit;
	logic [1:0]         ndigits;
	logic               lead_zero;

	logic verdict_q[$];

	task automatic report_mismatch(input string msg);
		$display("%0t ns: mismatch: %s", $time, msg);
		errors++;
	endtask

	task automatic close_field();
		number     = '0;
		ndigits    = '0;
		lead_zero  = 1'b0;
		prev_digit = 1'b0;
	endtask

	task automatic clear_scan();
		dots      = '0;
		colon_hit = 1'b0;
		broken    = 1'b0;
		close_field();
	endtask

	// advance the scan by one character, queue a verdict on the final one
	task automatic scan_char(input logic [CHAR_W-1:0] c, input logic is_final);
		int unsigned grown;
		logic        verdict;
		if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
			if (ndigits == 2'd0) begin
				lead_zero = (c == CHAR_ZERO);
			end else if (lead_zero) begin
				broken = 1'b1;
			end
			if (ndigits < DIGITS_FULL) begin
				ndigits = ndigits + 2'd1;
			end
			grown = 32'(number) * 32'd10 + 32'(c - CHAR_ZERO);
			// running value saturates one above the port range
			if (grown > 32'(VALUE_SAT)) begin
				grown = 32'(VALUE_SAT);
			end
			number = grown[VALUE_W-1:0];
			if (number > PORT_MAX) begin
				broken = 1'b1;
			end
			prev_digit = 1'b1;
		end else if (c == CHAR_DOT) begin
			if (!prev_digit || colon_hit || dots >= DOTS_FULL || number > OCTET_MAX) begin
				broken = 1'b1;
			end
			if (dots < DOTS_FULL) begin
				dots = dots + 2'd1;
			end
			close_field();
		end else if (c == CHAR_COLON) begin
			if (!prev_digit || colon_hit || dots != DOTS_FULL || number > OCTET_MAX) begin
				broken = 1'b1;
			end
			colon_hit = 1'b1;
			close_field();
		end else begin
			broken = 1'b1;
			close_field();
		end
		if (is_final) begin
			verdict = !broken && dots == DOTS_FULL && colon_hit && prev_digit &&
				number <= PORT_MAX;
			verdict_q.push_back(verdict);
			clear_scan();
		end
	endtask

	initial begin
		errors  = 0;
		pending = 0;
		clear_scan();
	end

	always @(posedge clk or negedge arst_n) begin
		logic exp_valid;
		if (!arst_n) begin
			clear_scan();
			verdict_q.delete();
		end else begin
			if (m_tvalid && m_tready) begin
				if (verdict_q.size() == 0) begin
					report_mismatch($sformatf("verdict 0x%02h with no text pending", m_tdata));
				end else begin
					exp_valid = verdict_q.pop_front();
					if (m_tdata[0] !== exp_valid) begin
						report_mismatch($sformatf("address_valid %b, expected %b",
							m_tdata[0], exp_valid));
					end
					if (m_tdata[7:1] !== 7'd0) begin
						report_mismatch($sformatf("tdata pad bits 0x%02h, expected zero",
							m_tdata[7:1]));
					end
				end
			end
			if (s_tvalid && s_tready) begin
				scan_char(s_tdata, s_tlast);
			end
		end
		pending = verdict_q.size();
	end

endmodule

// ===== tb/ipv4_port_text_validator_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv4_port_text_validator_unit_tb
// streams address texts into the validator: a directed set covering limits,
// separator misuse and leading zeros, then random address-shaped texts with
// random corruption and noise, under random stalls on both sides
// ----------------------------------------------------------------------------
module ipv4_port_text_validator_unit_tb;

	localparam int RANDOM_CHARS = 1125;
	localparam int CYCLE_LIMIT  = 200000;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       s_tvalid;
	logic       s_tready;
	logic [7:0] s_tdata;  // [7:0] char_code
	logic       s_tlast;  // last_char
	logic       m_tvalid;
	logic       m_tready;
	logic [7:0] m_tdata;  // [0] address_valid, [7:1] zero

	int   errors;
	int   pending;
	int   cycles;
	int   sent_chars;
	int   stall_left;
	logic idle_en;

	logic [7:0] text_q[$];

	ipv4_port_text_validator_unit u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	ipv4_port_text_validator_unit_checker u_checker (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.errors   (errors),
		.pending  (pending)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// verdict side backpressure in random bursts
	initial begin
		m_tready   = 1'b0;
		stall_left = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				m_tready = 1'b0;
				stall_left--;
			end else if (idle_en && $urandom_range(0, 5) == 0) begin
				m_tready = 1'b0;
				stall_left = $urandom_range(0, 14);
			end else begin
				m_tready = 1'b1;
			end
		end
	end

	// called at a falling edge, returns at the falling edge after the transfer
	task automatic send_char(input logic [7:0] c, input logic is_final);
		int gap;
		if (idle_en && $urandom_range(0, 9) == 0) begin
			s_tvalid = 1'b0;
			gap = $urandom_range(1, 15);
			repeat (gap) @(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata  = c;
		s_tlast  = is_final;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sent_chars++;
		@(negedge clk);
	endtask

	task automatic send_text();
		foreach (text_q[i]) begin
			send_char(text_q[i], i == text_q.size() - 1);
		end
	endtask

	task automatic load_string(input string s);
		text_q.delete();
		for (int i = 0; i < s.len(); i++) begin
			text_q.push_back(s[i]);
		end
	endtask

	task automatic send_string(input string s);
		load_string(s);
		send_text();
	endtask

	function automatic int unsigned pick_number(input int unsigned limit_val);
		case ($urandom_range(0, 7))
			0: return 0;
			1: return limit_val;
			2: return limit_val + 1;
			3: return $urandom_range(0, 9);
			4: return $urandom_range(limit_val, limit_val * 40);
			default: return $urandom_range(0, limit_val);
		endcase
	endfunction

	task automatic append_number(input int unsigned limit_val);
		string digits;
		digits = $sformatf("%0d", pick_number(limit_val));
		if ($urandom_range(0, 15) == 0) begin
			text_q.push_back(ipv4v_pkg::CHAR_ZERO);
		end
		for (int i = 0; i < digits.len(); i++) begin
			text_q.push_back(digits[i]);
		end
	endtask

	function automatic logic [7:0] pick_char();
		case ($urandom_range(0, 5))
			0: return ipv4v_pkg::CHAR_DOT;
			1: return ipv4v_pkg::CHAR_COLON;
			2, 3: return 8'($urandom_range(ipv4v_pkg::CHAR_ZERO, ipv4v_pkg::CHAR_NINE));
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic build_address();
		text_q.delete();
		for (int k = 0; k < 4; k++) begin
			append_number(255);
			text_q.push_back(k < 3 ? ipv4v_pkg::CHAR_DOT : ipv4v_pkg::CHAR_COLON);
		end
		append_number(65535);
	endtask

	// replace, drop or insert a character somewhere in the text
	task automatic corrupt_text();
		int pos;
		pos = $urandom_range(0, text_q.size() - 1);
		case ($urandom_range(0, 2))
			0: text_q[pos] = pick_char();
			1: if (text_q.size() > 1) text_q.delete(pos);
			default: text_q.insert(pos, pick_char());
		endcase
	endtask

	task automatic build_noise();
		int n;
		text_q.delete();
		n = $urandom_range(1, 10);
		repeat (n) text_q.push_back(pick_char());
	endtask

	initial begin
		int start_chars;
		arst_n     = 1'b0;
		s_tvalid   = 1'b0;
		s_tdata    = 8'd0;
		s_tlast    = 1'b0;
		idle_en    = 1'b1;
		cycles     = 0;
		sent_chars = 0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// limits, separator misuse, leading zeros, odd characters
		send_string("0.0.0.0:0");
		send_string("255.255.255.255:65535");
		send_string("256.1.1.1:80");
		send_string("1.1.1.1:65536");
		send_string("1.1.1.1:99999999");
		send_string("01.1.1.1:80");
		send_string("1.1.1.1:080");
		send_string("1.1.1.1.1:80");
		send_string("1.1.1:80");
		send_string("1.1.1.1:80:1");
		send_string("1.1.1.1:8.0");
		send_string(".1.1.1:80");
		send_string("1.1.1.1:");
		send_string("1..1.1:80");
		send_string("1.1.1.1");
		send_string("1.1.1.a:80");
		send_string("5");
		send_string(":");
		send_string("10.0.0.1:1");
		send_string("1.2.300.4:5");
		load_string("1.1.1.1:1");
		text_q.push_front(8'h00);
		send_text();
		send_char(8'hFF, 1'b1);

		start_chars = sent_chars;
		while (sent_chars - start_chars < RANDOM_CHARS) begin
			// calm stretches, and none at all near the end
			if (sent_chars - start_chars > RANDOM_CHARS - 250) begin
				idle_en = 1'b0;
			end else if ($urandom_range(0, 19) == 0) begin
				idle_en = !idle_en;
			end
			if ($urandom_range(0, 3) != 0) begin
				build_address();
				if ($urandom_range(0, 2) == 0) corrupt_text();
			end else begin
				build_noise();
			end
			send_text();
		end
		s_tvalid = 1'b0;
		s_tlast  = 1'b0;

		while (pending != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (errors == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
